// File: rtl/keypad_calculator_stopwatch_core_macros.svh
// Assertion macros for the keypad calculator / stopwatch core.
// Used by the port-level checker; needs clock and reset in scope.
`ifndef KEYPAD_CALCULATOR_STOPWATCH_CORE_MACROS_SVH
`define KEYPAD_CALCULATOR_STOPWATCH_CORE_MACROS_SVH

// Condition must hold in the same cycle as the trigger.
`define KCS_ASSERT_NOW(label, trig, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (trig) |-> (cond)) \
      else $error(msg);

// Condition must hold in the cycle after the trigger.
`define KCS_ASSERT_NEXT(label, trig, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (trig) |=> (cond)) \
      else $error(msg);

// Condition must hold in the cycle after reset is seen.
`define KCS_ASSERT_RESET(label, cond, msg) \
   label: assert property (@(posedge clock) reset |=> (cond)) \
      else $error(msg);

`endif

// File: rtl/kcs_pkg.sv
// Shared types and constants for the keypad calculator / stopwatch core.
// No dependencies; used by kcs_update, the top level and the checker.
`default_nettype none

package kcs_pkg;

   // Key codes
   localparam logic [3:0] KEY_DIGIT_MAX = 4'd9;
   localparam logic [3:0] KEY_CLR       = 4'd10;
   localparam logic [3:0] KEY_MODE      = 4'd11;
   localparam logic [3:0] KEY_ADD       = 4'd12;
   localparam logic [3:0] KEY_SUB       = 4'd13;
   localparam logic [3:0] KEY_MUL       = 4'd14;
   localparam logic [3:0] KEY_EQ        = 4'd15;

   // Limits
   localparam logic signed [31:0] ACC_DIGIT_LIMIT = 32'sd100000000;
   localparam logic [29:0]        OPB_DIGIT_LIMIT = 30'd100000000;
   localparam logic [6:0]         HUND_WRAP       = 7'd100;
   localparam logic [5:0]         SIXTY           = 6'd60;

   typedef enum logic [1:0] {
      PHASE_FIRST  = 2'd0,
      PHASE_SECOND = 2'd1,
      PHASE_RESULT = 2'd2
   } phase_type;

   typedef enum logic [1:0] {
      OP_NONE = 2'd0,
      OP_ADD  = 2'd1,
      OP_SUB  = 2'd2,
      OP_MUL  = 2'd3
   } op_type;

   // Architectural state
   typedef struct packed {
      logic               mode_bit;
      phase_type          phase;
      logic signed [31:0] accumulator;
      logic [29:0]        second_operand;
      op_type             pending_op;
      logic signed [31:0] saved_first;
      logic [29:0]        saved_second;
      op_type             saved_op;
      logic               overflow_mark;
      logic [5:0]         minutes;
      logic [5:0]         seconds;
      logic [6:0]         hundredths;
      logic               running;
   } state_type;

   // Result beat payload, last member in the lowest bits
   typedef struct packed {
      logic               pad;
      logic               running_now;
      logic [6:0]         hundredths_count;
      logic [5:0]         seconds_count;
      logic [5:0]         minutes_count;
      logic               overflow_seen;
      logic signed [31:0] result_value;
      logic [29:0]        right_value;
      logic [1:0]         operator_code;
      logic signed [31:0] left_value;
      logic [1:0]         entry_phase;
   } rsp_data_type;

endpackage

`default_nettype wire

// File: rtl/kcs_update.sv
// Next-state logic for one event of the calculator / stopwatch.
// Depends on kcs_pkg (state_type, key codes, phase and operator codes).
`default_nettype none

module kcs_update (
   input  kcs_pkg::state_type cur_state,
   input  logic               item_tick,
   input  logic [3:0]         item_key,
   output kcs_pkg::state_type nxt_state
);

   logic                is_digit;
   logic                is_op;
   kcs_pkg::op_type     key_op;
   logic [31:0]         acc_shift;
   logic [29:0]         opb_shift;
   logic signed [63:0]  a_wide;
   logic signed [63:0]  b_wide;
   logic signed [62:0]  product;
   logic signed [63:0]  wide_res;
   logic                res_fits;
   logic [6:0]          hund_inc;
   logic [5:0]          sec_inc;
   logic [5:0]          min_inc;

   // Key decode
   always_comb begin
      is_digit = (item_key <= kcs_pkg::KEY_DIGIT_MAX);
      is_op    = 1'b1;
      key_op   = kcs_pkg::OP_NONE;
      unique case (item_key)
         kcs_pkg::KEY_ADD: key_op = kcs_pkg::OP_ADD;
         kcs_pkg::KEY_SUB: key_op = kcs_pkg::OP_SUB;
         kcs_pkg::KEY_MUL: key_op = kcs_pkg::OP_MUL;
         default:          is_op  = 1'b0;
      endcase
   end

   // Digit append: x*10 + d, wrapping at the register width
   assign acc_shift = {cur_state.accumulator[28:0], 3'b000}
                    + {cur_state.accumulator[30:0], 1'b0}
                    + {28'd0, item_key};
   assign opb_shift = {cur_state.second_operand[26:0], 3'b000}
                    + {cur_state.second_operand[28:0], 1'b0}
                    + {26'd0, item_key};

   // Wide result for enter
   assign a_wide  = {{32{cur_state.accumulator[31]}}, cur_state.accumulator};
   assign b_wide  = {34'd0, cur_state.second_operand};
   assign product = $signed(cur_state.accumulator) * $signed({1'b0, cur_state.second_operand});

   always_comb begin
      unique case (cur_state.pending_op)
         kcs_pkg::OP_ADD: wide_res = a_wide + b_wide;
         kcs_pkg::OP_SUB: wide_res = a_wide - b_wide;
         kcs_pkg::OP_MUL: wide_res = {product[62], product};
         default:         wide_res = '0;
      endcase
   end

   assign res_fits = (wide_res[63:31] == {33{wide_res[31]}});

   // Stopwatch increments
   assign hund_inc = cur_state.hundredths + 7'd1;
   assign sec_inc  = cur_state.seconds + 6'd1;
   assign min_inc  = cur_state.minutes + 6'd1;

   // Event dispatch
   always_comb begin
      nxt_state = cur_state;
      priority if (item_tick) begin
         if (cur_state.running) begin
            if (hund_inc >= kcs_pkg::HUND_WRAP) begin
               nxt_state.hundredths = '0;
               if (sec_inc >= kcs_pkg::SIXTY) begin
                  nxt_state.seconds = '0;
                  nxt_state.minutes = (min_inc >= kcs_pkg::SIXTY) ? 6'd0 : min_inc;
               end else begin
                  nxt_state.seconds = sec_inc;
               end
            end else begin
               nxt_state.hundredths = hund_inc;
            end
         end
      end else if (item_key == kcs_pkg::KEY_MODE) begin
         nxt_state.mode_bit = ~cur_state.mode_bit;
         nxt_state.running  = 1'b0;
      end else if (cur_state.mode_bit) begin
         // stopwatch keys
         if (item_key == kcs_pkg::KEY_EQ) begin
            nxt_state.running = ~cur_state.running;
         end else if (item_key == kcs_pkg::KEY_CLR) begin
            nxt_state.running    = 1'b0;
            nxt_state.minutes    = '0;
            nxt_state.seconds    = '0;
            nxt_state.hundredths = '0;
         end
      end else begin
         // calculator keys
         unique case (cur_state.phase)
            kcs_pkg::PHASE_FIRST: begin
               if (is_digit) begin
                  if ($signed(cur_state.accumulator) < kcs_pkg::ACC_DIGIT_LIMIT)
                     nxt_state.accumulator = acc_shift;
               end else if (is_op) begin
                  nxt_state.pending_op = key_op;
                  nxt_state.phase      = kcs_pkg::PHASE_SECOND;
               end else if (item_key == kcs_pkg::KEY_CLR) begin
                  nxt_state.accumulator = '0;
               end
            end
            kcs_pkg::PHASE_SECOND: begin
               if (is_digit) begin
                  if (cur_state.second_operand < kcs_pkg::OPB_DIGIT_LIMIT)
                     nxt_state.second_operand = opb_shift;
               end else if (item_key == kcs_pkg::KEY_EQ) begin
                  nxt_state.saved_first   = cur_state.accumulator;
                  nxt_state.saved_second  = cur_state.second_operand;
                  nxt_state.saved_op      = cur_state.pending_op;
                  nxt_state.overflow_mark = ~res_fits;
                  nxt_state.accumulator   = res_fits ? wide_res[31:0] : 32'd0;
                  nxt_state.phase         = kcs_pkg::PHASE_RESULT;
               end else if (item_key == kcs_pkg::KEY_CLR) begin
                  nxt_state.accumulator    = '0;
                  nxt_state.second_operand = '0;
                  nxt_state.pending_op     = kcs_pkg::OP_NONE;
                  nxt_state.phase          = kcs_pkg::PHASE_FIRST;
               end
            end
            kcs_pkg::PHASE_RESULT: begin
               if (is_digit) begin
                  nxt_state.accumulator    = {28'd0, item_key};
                  nxt_state.second_operand = '0;
                  nxt_state.pending_op     = kcs_pkg::OP_NONE;
                  nxt_state.phase          = kcs_pkg::PHASE_FIRST;
               end else if (is_op) begin
                  nxt_state.pending_op     = key_op;
                  nxt_state.second_operand = '0;
                  nxt_state.phase          = kcs_pkg::PHASE_SECOND;
               end else if (item_key == kcs_pkg::KEY_CLR) begin
                  nxt_state.accumulator    = '0;
                  nxt_state.second_operand = '0;
                  nxt_state.pending_op     = kcs_pkg::OP_NONE;
                  nxt_state.phase          = kcs_pkg::PHASE_FIRST;
               end
            end
            default: ;
         endcase
      end
   end

endmodule

`default_nettype wire

// File: rtl/keypad_calculator_stopwatch_core.sv
// Keypad calculator and stopwatch core: input stage, state, result stage.
// Depends on kcs_pkg and kcs_update.
//
// Usage:
//   req channel: one beat per event. req_tuser = 0 for a key press with the
//   key code in req_tdata[3:0]; req_tuser = 1 for a 10 ms tick.
//   rsp channel: exactly one beat per req beat, in order, holding a snapshot
//   of the display state after that event. rsp_tuser is the mode (0
//   calculator, 1 stopwatch); rsp_tdata carries the remaining fields.
//   Path: a req beat passes the input register, then the result register,
//   before its result beat is offered on rsp. Throughput: one beat per
//   cycle while rsp_tready is high; the state update, including the single
//   32x31 multiply for enter, sits between those two registers.
//   Stall: while rsp_tready is low the result beat holds and one more event
//   waits in the input register; req_tready drops only when both are full.
//   Reset (synchronous, active high): calculator mode, first operand entry,
//   all values zero, stopwatch stopped, no beats in flight.
`default_nettype none

module keypad_calculator_stopwatch_core (
   input  logic         clock,
   input  logic         reset,
   // request channel
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [7:0]   req_tdata,   // [3:0] key_code, [7:4] zero
   input  logic         req_tuser,   // [0] req_type
   // result channel
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // [1:0] entry_phase, [33:2] left_value, [35:34] operator_code,
   // [65:36] right_value, [97:66] result_value, [98] overflow_seen,
   // [104:99] minutes_count, [110:105] seconds_count,
   // [117:111] hundredths_count, [118] running_now, [119] zero
   output logic [119:0] rsp_tdata,
   output logic         rsp_tuser    // [0] mode_now
);

   logic                  advance;
   logic                  req_beat;
   logic                  s1_vld_ff;
   logic                  s1_vld_in;
   logic                  s1_tick_ff;
   logic [3:0]            s1_key_ff;
   kcs_pkg::state_type    state_ff;
   kcs_pkg::state_type    state_in;
   logic                  rsp_vld_ff;
   logic                  rsp_vld_in;
   kcs_pkg::rsp_data_type rsp_data_ff;
   kcs_pkg::rsp_data_type rsp_data_in;
   logic                  rsp_mode_ff;
   logic                  shown;

   // Handshake
   assign advance    = !rsp_vld_ff || rsp_tready;
   assign req_tready = !s1_vld_ff || advance;
   assign req_beat   = req_tvalid && req_tready;
   assign s1_vld_in  = req_beat || (s1_vld_ff && !advance);
   assign rsp_vld_in = advance ? s1_vld_ff : rsp_vld_ff;

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff <= s1_vld_in;
      end
      if (req_beat) begin
         s1_tick_ff <= req_tuser;
         s1_key_ff  <= req_tdata[3:0];
      end
   end

   kcs_update u_kcs_update (
      .cur_state (state_ff),
      .item_tick (s1_tick_ff),
      .item_key  (s1_key_ff),
      .nxt_state (state_in)
   );

   // Display snapshot of the updated state
   always_comb begin
      shown = (state_in.phase == kcs_pkg::PHASE_RESULT);
      rsp_data_in                  = '0;
      rsp_data_in.entry_phase      = state_in.phase;
      rsp_data_in.left_value       = shown ? state_in.saved_first : state_in.accumulator;
      rsp_data_in.operator_code    = shown ? state_in.saved_op : state_in.pending_op;
      rsp_data_in.right_value      = shown ? state_in.saved_second : state_in.second_operand;
      rsp_data_in.result_value     = state_in.accumulator;
      rsp_data_in.overflow_seen    = state_in.overflow_mark;
      rsp_data_in.minutes_count    = state_in.minutes;
      rsp_data_in.seconds_count    = state_in.seconds;
      rsp_data_in.hundredths_count = state_in.hundredths;
      rsp_data_in.running_now      = state_in.running;
   end

   // State and result registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= '0;
         rsp_vld_ff <= 1'b0;
      end else begin
         rsp_vld_ff <= rsp_vld_in;
         if (s1_vld_ff && advance)
            state_ff <= state_in;
      end
      if (s1_vld_ff && advance) begin
         rsp_data_ff <= rsp_data_in;
         rsp_mode_ff <= state_in.mode_bit;
      end
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_mode_ff;

endmodule

`default_nettype wire

// File: rtl/kcs_checker.sv
// Port-level checker for keypad_calculator_stopwatch_core, bound to the top.
// Depends on kcs_pkg and keypad_calculator_stopwatch_core_macros.svh.
`default_nettype none

`include "keypad_calculator_stopwatch_core_macros.svh"

module kcs_checker (
   input logic         clock,
   input logic         reset,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [119:0] rsp_tdata,
   input logic         rsp_tuser
);

   kcs_pkg::rsp_data_type rsp_view;

   assign rsp_view = rsp_tdata;

   // No result beat right after reset
   `KCS_ASSERT_RESET(a_reset_idle, !rsp_tvalid, "result beat valid after reset")

   // Stalled beat holds
   `KCS_ASSERT_NEXT(a_stall_hold, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser), "stalled result beat changed")

   // An overflowed result shows as zero while the result is displayed
   `KCS_ASSERT_NOW(a_ovf_zero, rsp_tvalid && rsp_view.overflow_seen && (rsp_view.entry_phase == kcs_pkg::PHASE_RESULT), rsp_view.result_value == 32'sd0, "overflow result not zero")

   // Stopwatch digits stay in range
   `KCS_ASSERT_NOW(a_clock_range, rsp_tvalid, (rsp_view.hundredths_count < kcs_pkg::HUND_WRAP) && (rsp_view.seconds_count < kcs_pkg::SIXTY) && (rsp_view.minutes_count < kcs_pkg::SIXTY), "stopwatch count out of range")

endmodule

bind keypad_calculator_stopwatch_core kcs_checker u_kcs_checker (.*);

`default_nettype wire
